// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file spq_checker.sv.
// No dependencies; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/spq_pkg.sv =====
// Shared constants, codes and types of the sorted priority queue.
// No dependencies; used by every other file of the block but assert_macros.svh.
package spq_pkg;

	localparam int DEPTH  = 16;
	localparam int VAL_W  = 16;
	localparam int PRI_W  = 8;
	localparam int CAP_W  = 5;
	localparam int HELD_W = 5;
	localparam int OCC_W  = $clog2(DEPTH + 1);
	localparam int CMP_W  = (OCC_W > CAP_W) ? OCC_W : CAP_W;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	// operation codes
	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} spq_status_t;

	// one slot of the queue
	typedef struct packed {
		logic signed [VAL_W-1:0] value;
		logic [PRI_W-1:0]        prio;
	} spq_entry_t;

	// command broadcast to every cell
	typedef struct packed {
		logic       push;
		logic       pop;
		spq_entry_t item;
	} spq_cmd_t;

endpackage

// ===== hdl/spq_req_if.sv =====
// Request channel of the sorted priority queue: push or pop beats.
// Depends on spq_pkg.
interface spq_req_if;
	logic                            valid;
	logic                            ready;
	logic                            operation;
	logic signed [spq_pkg::VAL_W-1:0] item_value;
	logic [spq_pkg::PRI_W-1:0]       item_priority;

	modport source (output valid, operation, item_value, item_priority, input ready);
	modport sink   (input valid, operation, item_value, item_priority, output ready);
endinterface

// ===== hdl/spq_rsp_if.sv =====
// Response channel of the sorted priority queue: one beat per request.
// Depends on spq_pkg.
interface spq_rsp_if;
	logic                             valid;
	logic                             ready;
	logic signed [spq_pkg::VAL_W-1:0] popped_value;
	logic [1:0]                       status;
	logic [spq_pkg::HELD_W-1:0]       entries_held;

	modport source (output valid, popped_value, status, entries_held, input ready);
	modport sink   (input valid, popped_value, status, entries_held, output ready);
endinterface

// ===== hdl/spq_cell.sv =====
// One slot of the sorted chain: holds an entry, compares against a push,
// and shifts with its neighbors. Depends on spq_pkg.
module spq_cell (
	input  logic               clk,
	input  spq_pkg::spq_cmd_t  cmd,
	input  logic               occupied,
	input  logic               left_keep,
	input  spq_pkg::spq_entry_t left_entry,
	input  spq_pkg::spq_entry_t right_entry,
	output logic               keep,
	output spq_pkg::spq_entry_t entry
);

	spq_pkg::spq_entry_t entry_q;

	// entry stays put on a push when it ranks equal or higher
	assign keep  = occupied && (entry_q.prio >= cmd.item.prio);
	assign entry = entry_q;

	// push: hold, take the new item at the insertion point, or shift back
	// pop: shift forward from the right neighbor
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			if (!keep) begin
				entry_q <= left_keep ? cmd.item : left_entry;
			end
		end else if (cmd.pop) begin
			entry_q <= right_entry;
		end
	end

endmodule

// ===== hdl/spq_ctrl.sv =====
// Occupancy, capacity register and response register of the queue.
// Depends on spq_pkg.
module spq_ctrl (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_accept,
	input  logic                             operation,
	input  logic signed [spq_pkg::VAL_W-1:0] item_value,
	input  logic [spq_pkg::PRI_W-1:0]        item_priority,
	input  logic signed [spq_pkg::VAL_W-1:0] head_value,
	input  logic                             rsp_ready,
	input  logic                             cfg_we,
	input  logic [spq_pkg::CAP_W-1:0]        cfg_wdata,
	output spq_pkg::spq_cmd_t                cmd,
	output logic [spq_pkg::OCC_W-1:0]        occ,
	output logic                             req_ready,
	output logic                             rsp_valid,
	output logic signed [spq_pkg::VAL_W-1:0] popped_value,
	output logic [1:0]                       status,
	output logic [spq_pkg::HELD_W-1:0]       entries_held
);

	logic [spq_pkg::OCC_W-1:0]        occ_q, occ_d;
	logic [spq_pkg::CAP_W-1:0]        cap_q;
	logic                             rsp_valid_q;
	logic signed [spq_pkg::VAL_W-1:0] popped_q, popped_d;
	spq_pkg::spq_status_t             status_q, status_d;
	logic [spq_pkg::HELD_W-1:0]       held_q;
	logic                             full, empty;

	// limit saturates at the depth; occupancy never exceeds it
	assign full  = (spq_pkg::CMP_W'(occ_q) >= spq_pkg::CMP_W'(cap_q)) ||
	               (occ_q == spq_pkg::OCC_W'(spq_pkg::DEPTH));
	assign empty = (occ_q == '0);

	// decode the accepted request
	always_comb begin
		cmd.push      = 1'b0;
		cmd.pop       = 1'b0;
		cmd.item.value = item_value;
		cmd.item.prio  = item_priority;
		occ_d         = occ_q;
		status_d      = spq_pkg::ST_DONE;
		popped_d      = '0;
		if (req_accept) begin
			unique case (operation)
				spq_pkg::OP_PUSH: begin
					if (full) begin
						status_d = spq_pkg::ST_FULL;
					end else begin
						cmd.push = 1'b1;
						occ_d    = occ_q + spq_pkg::OCC_W'(1);
					end
				end
				spq_pkg::OP_POP: begin
					if (empty) begin
						status_d = spq_pkg::ST_EMPTY;
					end else begin
						cmd.pop  = 1'b1;
						popped_d = head_value;
						occ_d    = occ_q - spq_pkg::OCC_W'(1);
					end
				end
			endcase
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q       <= '0;
			cap_q       <= spq_pkg::CAP_RESET;
			rsp_valid_q <= 1'b0;
		end else begin
			occ_q <= occ_d;
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (req_accept) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// response payload
	always_ff @(posedge clk) begin
		if (req_accept) begin
			popped_q <= popped_d;
			status_q <= status_d;
			held_q   <= spq_pkg::HELD_W'(occ_d);
		end
	end

	assign occ          = occ_q;
	assign req_ready    = !rsp_valid_q || rsp_ready;
	assign rsp_valid    = rsp_valid_q;
	assign popped_value = popped_q;
	assign status       = status_q;
	assign entries_held = held_q;

endmodule

// ===== hdl/sorted_priority_queue.sv =====
// Sorted priority queue, highest priority at the head.
// Request channel req carries operation (push or pop), item_value and
// item_priority; every accepted request beat produces exactly one beat on
// the response channel rsp with popped_value, status and entries_held.
// A push lands behind all entries of equal or higher priority; a push at
// capacity is refused with status full, a pop of an empty queue with
// status empty. cfg_we/cfg_wdata write the capacity limit (saturates at
// the depth); write it only while no request is in flight.
// Throughput: one request per cycle. All cells compare and shift in
// parallel in the cycle of acceptance, and the response register shows
// the result in the cycle after the request is accepted.
// Stall: while rsp is held by the receiver, one more request is accepted
// only in the cycle the waiting response is taken; req.ready is low when
// a response waits and rsp.ready is low.
// Reset (arst_n low): queue empties, capacity returns to 16, no response
// is pending. Slot contents are not cleared; only occupied slots are read.
// Depends on spq_pkg, spq_req_if, spq_rsp_if, spq_cell and spq_ctrl.
module sorted_priority_queue (
	input  logic                         clk,
	input  logic                         arst_n,
	spq_req_if.sink                      req,
	spq_rsp_if.source                    rsp,
	input  logic                         cfg_we,
	input  logic [spq_pkg::CAP_W-1:0]    cfg_wdata
);

	spq_pkg::spq_cmd_t         cmd;
	logic [spq_pkg::OCC_W-1:0] occ;
	logic                      req_accept;
	spq_pkg::spq_entry_t       entry_w [spq_pkg::DEPTH];
	logic                      keep_w  [spq_pkg::DEPTH];

	assign req_accept = req.valid && req.ready;

	// control and response register
	spq_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_accept   (req_accept),
		.operation    (req.operation),
		.item_value   (req.item_value),
		.item_priority(req.item_priority),
		.head_value   (entry_w[0].value),
		.rsp_ready    (rsp.ready),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.cmd          (cmd),
		.occ          (occ),
		.req_ready    (req.ready),
		.rsp_valid    (rsp.valid),
		.popped_value (rsp.popped_value),
		.status       (rsp.status),
		.entries_held (rsp.entries_held)
	);

	// chain of slots, slot 0 is the head
	for (genvar i = 0; i < spq_pkg::DEPTH; i++) begin : g_cell
		logic                lk;
		spq_pkg::spq_entry_t le;
		spq_pkg::spq_entry_t re;
		logic                occupied;

		assign occupied = (spq_pkg::OCC_W'(i) < occ);

		if (i == 0) begin : g_head
			assign lk = 1'b1;
			assign le = '0;
		end else begin : g_body
			assign lk = keep_w[i-1];
			assign le = entry_w[i-1];
		end

		if (i == spq_pkg::DEPTH - 1) begin : g_tail
			assign re = '0;
		end else begin : g_mid
			assign re = entry_w[i+1];
		end

		spq_cell u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.occupied   (occupied),
			.left_keep  (lk),
			.left_entry (le),
			.right_entry(re),
			.keep       (keep_w[i]),
			.entry      (entry_w[i])
		);
	end

endmodule

// ===== hdl/spq_checker.sv =====
// Port-level checks of the sorted priority queue, bound to the top level.
// Depends on spq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module spq_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             req_valid,
	input logic                             req_ready,
	input logic                             rsp_valid,
	input logic                             rsp_ready,
	input logic signed [spq_pkg::VAL_W-1:0] popped_value,
	input logic [1:0]                       status,
	input logic [spq_pkg::HELD_W-1:0]       entries_held
);

	// a waiting response holds until taken
	`ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(status) && $stable(popped_value) && $stable(entries_held), "response changed while stalled")

	// every accepted request yields a response in the next cycle
	`ASSERT_NEXT(a_req_to_rsp, clk, arst_n, req_valid && req_ready, rsp_valid, "accepted request without response")

	// with no response waiting the queue takes requests
	`ASSERT_IMPLY(a_ready_idle, clk, arst_n, !rsp_valid, req_ready, "ready low with no response pending")

	// a refused pop reports an empty queue and no value
	`ASSERT_IMPLY(a_empty_pop, clk, arst_n, rsp_valid && (status == spq_pkg::ST_EMPTY), (entries_held == '0) && (popped_value == '0), "empty status with held entries or value")

	// occupancy never exceeds the depth
	`ASSERT_IMPLY(a_held_max, clk, arst_n, rsp_valid, spq_pkg::CMP_W'(entries_held) <= spq_pkg::CMP_W'(spq_pkg::DEPTH), "entries held above depth")

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.popped_value(rsp.popped_value),
	.status      (rsp.status),
	.entries_held(rsp.entries_held)
);
